// ----- rtl/refcounted_hash_set_assert.svh -----
// Assertion macros used by the hash set RTL.
`ifndef REFCOUNTED_HASH_SET_ASSERT_SVH
`define REFCOUNTED_HASH_SET_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define RHS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash set same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define RHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash set next-cycle check failed");

`endif

// ----- rtl/rhs_pkg.sv -----
// Package with sizes, codes, entry types and the bucket hash of the hash set.
package rhs_pkg;

  localparam int BUCKETS    = 256;
  localparam int BKT_BITS   = 8;
  localparam int WAYS       = 4;
  localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int COUNT_BITS = 16;
  localparam int KEY_BITS   = 64;
  localparam int REF_BITS   = 16;
  localparam int STAT_BITS  = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_BITS-1:0] ST_INCREMENTED = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_INSERTED    = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_DECREMENTED = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_FREED       = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [STAT_BITS-1:0] ST_BUCKET_FULL = 3'd5;
  localparam logic [STAT_BITS-1:0] ST_SATURATED   = 3'd6;

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  // CRC-8, polynomial 0x07, zero initial value, key bytes least significant first.
  function automatic logic [BKT_BITS-1:0] crc8_key(input logic [KEY_BITS-1:0] k);
    logic [7:0] crc;
    crc = 8'h00;
    for (int b = 0; b < 8; b++) begin
      crc = crc ^ k[8*b +: 8];
      for (int i = 0; i < 8; i++) begin
        crc = crc[7] ? ({crc[6:0], 1'b0} ^ 8'h07) : {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ----- rtl/refcounted_hash_set.sv -----
// Top level of the reference-counted hash set with its bucket memory.
//
// Requests enter on the in_ channel: in_tuser carries the operation (add or
// remove a reference) and in_tdata the 64-bit key. Each request gives exactly
// one result on the out_ channel: out_tuser carries the status code and
// out_tdata the count after the operation and the key's CRC-8 bucket.
// Keys hash to 256 buckets of four ways; one memory row holds a whole bucket.
// The accept edge reads the bucket row into a register; then, in the lookup
// state, the block compares all ways at once, writes the row back and loads
// the output register. A new request is taken only after the previous one
// has left the lookup state. After reset the block clears the bucket memory,
// one row per cycle, with in_tready low. When the receiver stalls, one
// finished result waits in the output register while the next request is
// still accepted and looked up; that request then holds until the output
// register frees up.
module refcounted_hash_set
  import rhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // [63:0] key
  input  logic        in_tuser,  // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // [15:0] ref_count, [23:16] bucket
  output logic [2:0]  out_tuser  // [2:0] status
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  row_t mem [BUCKETS];

  logic [1:0]            state_r, state_nxt;
  logic [BKT_BITS-1:0]   clr_addr_r, clr_addr_nxt;
  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [BKT_BITS-1:0]   bkt_r;
  row_t                  rd_row_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_BITS-1:0]  out_status_r;
  logic [REF_BITS-1:0]   out_count_r;
  logic [BKT_BITS-1:0]   out_bkt_r;

  logic                  in_acc;
  logic                  go;
  logic                  hit, free;
  logic [WAY_BITS-1:0]   hit_way, free_way;
  logic [COUNT_BITS-1:0] sel_cnt, res_cnt;
  logic [STAT_BITS-1:0]  res_status;
  row_t                  row_nxt;
  logic                  wr_en;
  logic [BKT_BITS-1:0]   wr_addr;
  row_t                  wr_data;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign go        = (state_r == S_LOOK) && (!out_valid_r || out_tready);

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_row_r[w].valid) begin
        if (!hit && rd_row_r[w].key == key_r) begin
          hit     = 1'b1;
          hit_way = WAY_BITS'(w);
        end
      end else if (!free) begin
        free     = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
  end

  assign sel_cnt = rd_row_r[hit_way].count;

  always_comb begin
    row_nxt    = rd_row_r;
    res_cnt    = '0;
    res_status = ST_NOT_FOUND;
    if (op_r == OP_ADD) begin
      if (hit) begin
        if (sel_cnt == COUNT_MAX) begin
          res_cnt    = COUNT_MAX;
          res_status = ST_SATURATED;
        end else begin
          res_cnt    = sel_cnt + COUNT_BITS'(1);
          res_status = ST_INCREMENTED;
        end
        row_nxt[hit_way].count = res_cnt;
      end else if (free) begin
        row_nxt[free_way].valid = 1'b1;
        row_nxt[free_way].key   = key_r;
        row_nxt[free_way].count = COUNT_BITS'(1);
        res_cnt    = COUNT_BITS'(1);
        res_status = ST_INSERTED;
      end else begin
        res_status = ST_BUCKET_FULL;
      end
    end else begin
      if (hit) begin
        res_cnt = (sel_cnt == '0) ? '0 : sel_cnt - COUNT_BITS'(1);
        row_nxt[hit_way].count = res_cnt;
        if (res_cnt == '0) begin
          row_nxt[hit_way].valid = 1'b0;
          res_status = ST_FREED;
        end else begin
          res_status = ST_DECREMENTED;
        end
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = bkt_r;
    wr_data = row_nxt;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (go) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_acc) begin
      rd_row_r <= mem[crc8_key(in_tdata)];
      op_r     <= in_tuser;
      key_r    <= in_tdata;
      bkt_r    <= crc8_key(in_tdata);
    end
    if (go) begin
      out_status_r <= res_status;
      out_count_r  <= REF_BITS'(res_cnt);
      out_bkt_r    <= bkt_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + BKT_BITS'(1);
        if (clr_addr_r == BKT_BITS'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_bkt_r, out_count_r};
  assign out_tuser  = out_status_r;

`include "refcounted_hash_set_assert.svh"

  `RHS_ASSERT_NOW(a_no_accept_in_clear, state_r == S_CLEAR, !in_tready)
  `RHS_ASSERT_NEXT(a_accept_to_lookup, in_acc, state_r == S_LOOK)
  `RHS_ASSERT_NEXT(a_lookup_loads_output, go, out_valid_r && state_r == S_IDLE)
  `RHS_ASSERT_NOW(a_freed_count_zero, out_valid_r && out_status_r == ST_FREED,
                  out_count_r == '0)

endmodule

// ----- bench/tb_refcounted_hash_set.sv -----
// Testbench for the reference-counted hash set: directed and random add/remove traffic.
module tb_refcounted_hash_set;
  import rhs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES     = BUCKETS * WAYS;
  localparam int CYCLE_LIMIT = 100000;
  localparam int POOL_SIZE   = 24;

  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic [REF_BITS-1:0]  ref_count;
    logic [BKT_BITS-1:0]  bucket;
  } result_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;

  logic                  tab_valid [ENTRIES];
  logic [KEY_BITS-1:0]   tab_key   [ENTRIES];
  logic [COUNT_BITS-1:0] tab_count [ENTRIES];

  result_t  awaited_results[$];
  int       errors = 0;
  int       mismatches = 0;
  int       cycles = 0;
  int       burst_left = 0;
  bit       tx_gaps = 1'b1;
  rx_mode_e rx_mode = RX_ALWAYS;
  bit       hold_req = 1'b0;
  int       hold_cycles = 0;
  int       rx_phase = 0;

  refcounted_hash_set u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [63:0] key
    .in_tuser  (in_tuser),   // [0] op
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [15:0] ref_count, [23:16] bucket
    .out_tuser (out_tuser)   // [2:0] status
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_refcounted_hash_set: errors");
      $finish;
    end
  end

  // The key is fed as one bit stream: each byte from least significant up, each byte MSB first.
  function automatic logic [BKT_BITS-1:0] bucket_of(input logic [KEY_BITS-1:0] k);
    logic [7:0] crc;
    logic       fb;
    crc = 8'h00;
    for (int j = 0; j < KEY_BITS; j++) begin
      fb  = crc[7] ^ k[8 * (j / 8) + 7 - (j % 8)];
      crc = {crc[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
    end
    return crc;
  endfunction

  function automatic logic [KEY_BITS-1:0] key_in_bucket(input logic [BKT_BITS-1:0] b);
    logic [KEY_BITS-1:0] k;
    do begin
      k = {$urandom, $urandom};
    end while (bucket_of(k) != b);
    return k;
  endfunction

  function automatic result_t apply_ref_op(input logic op, input logic [KEY_BITS-1:0] k);
    result_t               r;
    int                    base;
    int                    hit;
    int                    free_way;
    int                    e;
    logic [COUNT_BITS-1:0] c;
    r.bucket    = bucket_of(k);
    r.ref_count = '0;
    base        = int'(r.bucket) * WAYS;
    hit         = -1;
    free_way    = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (tab_valid[base + w]) begin
        if (hit < 0 && tab_key[base + w] == k) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (op == OP_ADD) begin
      if (hit >= 0) begin
        e = base + hit;
        if (tab_count[e] == COUNT_MAX) begin
          r.status = ST_SATURATED;
        end else begin
          tab_count[e] = tab_count[e] + 1'b1;
          r.status     = ST_INCREMENTED;
        end
        r.ref_count = REF_BITS'(tab_count[e]);
      end else if (free_way >= 0) begin
        e            = base + free_way;
        tab_valid[e] = 1'b1;
        tab_key[e]   = k;
        tab_count[e] = COUNT_BITS'(1);
        r.ref_count  = REF_BITS'(1);
        r.status     = ST_INSERTED;
      end else begin
        r.status = ST_BUCKET_FULL;
      end
    end else begin
      if (hit >= 0) begin
        e = base + hit;
        c = (tab_count[e] == '0) ? '0 : tab_count[e] - 1'b1;
        tab_count[e] = c;
        if (c == '0) begin
          tab_valid[e] = 1'b0;
          r.status     = ST_FREED;
        end else begin
          r.status = ST_DECREMENTED;
        end
        r.ref_count = REF_BITS'(c);
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic op, input logic [KEY_BITS-1:0] k);
    int gap;
    if (tx_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(1, 5);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= k;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    awaited_results.push_back(apply_ref_op(op, k));
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_tready <= 1'b1;
          RX_RANDOM:  out_tready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_tready <= ((rx_phase % 7) < 4);
          default:    out_tready <= ($urandom_range(0, 9) == 0);
        endcase
        rx_phase++;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[15:0], out_tdata[23:16]};
      if (awaited_results.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d count %0d bucket %0d",
                   got.status, got.ref_count, got.bucket);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d count %0d bucket %0d, got %0d %0d %0d",
                     want.status, want.ref_count, want.bucket,
                     got.status, got.ref_count, got.bucket);
        end
      end
    end
  end

  task automatic test_add_remove_extremes();
    send_item(OP_ADD, 64'h0);
    send_item(OP_ADD, 64'h0);
    send_item(OP_REMOVE, 64'h0);
    send_item(OP_REMOVE, 64'h0);
    send_item(OP_REMOVE, 64'h0);
    send_item(OP_ADD, '1);
    send_item(OP_ADD, '1);
    send_item(OP_REMOVE, '1);
    send_item(OP_REMOVE, '1);
    send_item(OP_REMOVE, 64'h8000_0000_0000_0001);
  endtask

  task automatic test_bucket_full();
    logic [KEY_BITS-1:0] ks [WAYS+1];
    for (int i = 0; i <= WAYS; i++) ks[i] = key_in_bucket(8'hff);
    for (int i = 0; i <= WAYS; i++) send_item(OP_ADD, ks[i]);
    send_item(OP_REMOVE, ks[WAYS]);
    send_item(OP_REMOVE, ks[1]);
    send_item(OP_ADD, ks[WAYS]);
    send_item(OP_ADD, ks[1]);
    for (int i = 0; i <= WAYS; i++) send_item(OP_REMOVE, ks[i]);
  endtask

  task automatic test_count_run();
    logic [KEY_BITS-1:0] k;
    k       = {$urandom, $urandom};
    tx_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    for (int i = 0; i < 16; i++) send_item(OP_ADD, k);
    for (int i = 0; i < 17; i++) send_item(OP_REMOVE, k);
    send_item(OP_ADD, k);
    tx_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    logic [KEY_BITS-1:0] k;
    tx_gaps     = 1'b0;
    rx_mode     = RX_RANDOM;
    hold_cycles = 300;
    hold_req    = 1'b1;
    k           = {$urandom, $urandom};
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 2) send_item(OP_REMOVE, k);
      else send_item(OP_ADD, (i % 4 == 0) ? {$urandom, $urandom} : k);
    end
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_mix();
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    logic [BKT_BITS-1:0] hot_a;
    logic [BKT_BITS-1:0] hot_b;
    logic [KEY_BITS-1:0] k;
    int                  r;
    hot_a = BKT_BITS'($urandom_range(0, 255));
    hot_b = BKT_BITS'($urandom_range(0, 255));
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 6) key_pool[i] = key_in_bucket(hot_a);
      else if (i < 12) key_pool[i] = key_in_bucket(hot_b);
      else key_pool[i] = {$urandom, $urandom};
    end
    for (int n = 0; n < 750; n++) begin
      if (n % 100 == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        tx_gaps = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 50) begin
        send_item(OP_ADD, k);
      end else if (r < 85) begin
        send_item(OP_REMOVE, k);
      end else if (r < 93) begin
        send_item(logic'($urandom_range(0, 1)), {$urandom, $urandom});
      end else begin
        k = 64'h1 << $urandom_range(0, 63);
        send_item(logic'($urandom_range(0, 1)), ($urandom_range(0, 1) != 0) ? ~k : k);
      end
    end
  endtask

  initial begin
    for (int e = 0; e < ENTRIES; e++) begin
      tab_valid[e] = 1'b0;
      tab_key[e]   = '0;
      tab_count[e] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    rx_mode = RX_RANDOM;
    test_add_remove_extremes();
    test_bucket_full();
    test_count_run();
    test_backpressure();
    test_random_mix();
    in_tvalid <= 1'b0;
    rx_mode = RX_ALWAYS;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_refcounted_hash_set: clean");
    end else begin
      $display("tb_refcounted_hash_set: errors");
    end
    $finish;
  end

endmodule
